// File: rtl/core/hlva_pkg.sv
// Shared types, codes and the fixed-point sine function of the Hough vote accumulator.
// Used by the top level, front, queue and back end; depends on nothing.
`timescale 1ns / 1ps
package hlva_pkg;

   // Request action codes.
   localparam logic [1:0] ACT_VOTE  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_WEIGHT    = 3'd1;
   localparam logic [2:0] CSR_SCALE     = 3'd2;
   localparam logic [2:0] CSR_ROWS      = 3'd3;
   localparam logic [2:0] CSR_COLS      = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   // What the back end has to do with a request.
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_VOTE  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // One classified request as it waits in the queue.
   typedef struct packed {
      kind_type           kind;
      logic signed [10:0] dy;
      logic signed [10:0] dx;
      logic [16:0]        add;
      logic [7:0]         rb;
      logic [7:0]         ab;
   } entry_type;

   // Head of the queue as the back end sees it.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   // Sine of a phase (2^32 per turn) in Q1.14; evaluated only on constants.
   function automatic logic signed [15:0] sin_q14(input logic [31:0] p);
      logic [63:0] u;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic signed [15:0] v;
      u = {34'd0, p[29:0]};
      if (p[30]) begin
         u = 64'd1073741824 - u;
      end
      x  = (u * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824;
      t  = 64'd1073741824 - (((x2 * t) >> 30) / 156);
      t  = 64'd1073741824 - (((x2 * t) >> 30) / 110);
      t  = 64'd1073741824 - (((x2 * t) >> 30) / 72);
      t  = 64'd1073741824 - (((x2 * t) >> 30) / 42);
      t  = 64'd1073741824 - (((x2 * t) >> 30) / 20);
      t  = 64'd1073741824 - (((x2 * t) >> 30) / 6);
      s  = (x * t) >> 30;
      s  = (s + 64'd32768) >> 16;
      if (s > 64'd16384) begin
         s = 64'd16384;
      end
      v = 16'(s);
      return p[31] ? -v : v;
   endfunction

endpackage

// File: rtl/core/hough_line_vote_accumulator.sv
// Top level of the Hough line vote accumulator: registers, front, queue, back end.
// Depends on hlva_pkg, hlva_front, hlva_queue and hlva_back.
`timescale 1ns / 1ps
// Usage:
// A request is taken when start is high and busy is low. Action vote sends a
// pixel through NUM_ANGLES angle steps, one step per cycle, each updating at
// most one cell, and holds the back end until its vote pipeline has drained.
// A read returns the bin through the registered memory read, a clear sweeps
// all NUM_RADIUS*NUM_ANGLES cells one per cycle, and ignored votes, invalid
// actions and out-of-range reads are answered from the idle state.
// A two-entry queue lets new requests in while the back end is working;
// busy rises when it is full.
// Each request gives one response, shown for one cycle with rsp_valid high.
// The receiver cannot stall, so responses are never held back.
// The csr channel writes a register when csr_valid is high; csr_ready is
// always high. Write registers only while the block is idle.
// After reset the accumulator is cleared by a sweep of all NUM_RADIUS*NUM_ANGLES
// cells with busy high; register writes are taken during the sweep.
module hough_line_vote_accumulator #(
   parameter int NUM_RADIUS = 256,
   parameter int NUM_ANGLES = 256,
   parameter int ACC_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [9:0]  req_pixel_row,
   input  logic [9:0]  req_pixel_col,
   input  logic [15:0] req_pixel_value,
   input  logic [7:0]  req_radius_bin,
   input  logic [7:0]  req_angle_bin,
   output logic        rsp_valid,
   output logic [31:0] rsp_bin_value,
   output logic [8:0]  rsp_votes_cast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import hlva_pkg::*;

   logic [15:0] threshold_ff;
   logic [15:0] weight_ff;
   logic [23:0] scale_ff;
   logic [10:0] rows_ff;
   logic [10:0] cols_ff;

   entry_type entry;
   head_type  head;
   logic      full;
   logic      pop;
   logic      init_busy;
   logic      accept;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 16'd0;
         weight_ff    <= 16'd0;
         scale_ff     <= 24'd65536;
         rows_ff      <= 11'd1024;
         cols_ff      <= 11'd1024;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data[15:0];
            CSR_WEIGHT:    weight_ff    <= csr_data[15:0];
            CSR_SCALE:     scale_ff     <= csr_data[23:0];
            CSR_ROWS:      rows_ff      <= csr_data[10:0];
            CSR_COLS:      cols_ff      <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // Request acceptance.
   assign busy   = full || init_busy;
   assign accept = start && !busy;

   hlva_front #(.NUM_RADIUS(NUM_RADIUS), .NUM_ANGLES(NUM_ANGLES)) u_front (
      .action      (req_action),
      .pixel_row   (req_pixel_row),
      .pixel_col   (req_pixel_col),
      .pixel_value (req_pixel_value),
      .radius_bin  (req_radius_bin),
      .angle_bin   (req_angle_bin),
      .threshold   (threshold_ff),
      .weight      (weight_ff),
      .image_rows  (rows_ff),
      .image_cols  (cols_ff),
      .entry       (entry)
   );

   hlva_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .full       (full)
   );

   hlva_back #(
      .NUM_RADIUS (NUM_RADIUS),
      .NUM_ANGLES (NUM_ANGLES),
      .ACC_BITS   (ACC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .radius_scale   (scale_ff),
      .pop            (pop),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_valid),
      .rsp_bin_value  (rsp_bin_value),
      .rsp_votes_cast (rsp_votes_cast)
   );

endmodule

// File: rtl/core/hlva_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module hlva_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/hlva_front.sv
// Front end: classifies an accepted request into a queue entry.
// Depends on hlva_pkg.
`timescale 1ns / 1ps
module hlva_front #(
   parameter int NUM_RADIUS = 256,
   parameter int NUM_ANGLES = 256
) (
   input  logic [1:0]           action,
   input  logic [9:0]           pixel_row,
   input  logic [9:0]           pixel_col,
   input  logic [15:0]          pixel_value,
   input  logic [7:0]           radius_bin,
   input  logic [7:0]           angle_bin,
   input  logic [15:0]          threshold,
   input  logic [15:0]          weight,
   input  logic [10:0]          image_rows,
   input  logic [10:0]          image_cols,
   output hlva_pkg::entry_type  entry
);
   import hlva_pkg::*;

   logic read_ok;

   // A read outside the accumulator returns zero without touching memory.
   assign read_ok = (13'(radius_bin) < 13'(NUM_RADIUS)) && (13'(angle_bin) < 13'(NUM_ANGLES));

   // Offsets from the image centre and the vote weight.
   always_comb begin
      entry.dy  = $signed({1'b0, pixel_row}) - $signed({1'b0, image_rows[10:1]});
      entry.dx  = $signed({1'b0, pixel_col}) - $signed({1'b0, image_cols[10:1]});
      entry.add = {1'b0, pixel_value} + {1'b0, weight};
      entry.rb  = radius_bin;
      entry.ab  = angle_bin;
      case (action)
         ACT_VOTE:  entry.kind = (pixel_value > threshold) ? KIND_VOTE : KIND_NONE;
         ACT_READ:  entry.kind = read_ok ? KIND_READ : KIND_NONE;
         ACT_CLEAR: entry.kind = KIND_CLEAR;
         default:   entry.kind = KIND_NONE;
      endcase
   end

endmodule

// File: rtl/core/hlva_queue.sv
// Short queue of classified requests between front and back end.
// Depends on hlva_pkg.
`timescale 1ns / 1ps
module hlva_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hlva_pkg::entry_type push_entry,
   input  logic                pop,
   output hlva_pkg::head_type  head,
   output logic                full
);
   import hlva_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);

   entry_type     slot_ff [QUEUE_DEPTH];
   logic [QW-1:0] wr_ff, wr_in;
   logic [QW-1:0] rd_ff, rd_in;
   logic [QW:0]   cnt_ff, cnt_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.entry = slot_ff[rd_ff];
   assign full       = (cnt_ff == (QW+1)'(QUEUE_DEPTH));

endmodule

// File: rtl/core/hlva_back.sv
// Back end: vote pipeline over all angles, bin reads and clearing sweeps.
// Depends on hlva_pkg and hlva_ram.
`timescale 1ns / 1ps
module hlva_back #(
   parameter int NUM_RADIUS = 256,
   parameter int NUM_ANGLES = 256,
   parameter int ACC_BITS   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  hlva_pkg::head_type head,
   input  logic [23:0]        radius_scale,
   output logic               pop,
   output logic               init_busy,
   output logic               rsp_valid,
   output logic [31:0]        rsp_bin_value,
   output logic [8:0]         rsp_votes_cast
);
   import hlva_pkg::*;

   localparam int CELLS = NUM_RADIUS * NUM_ANGLES;
   localparam int AW    = $clog2(CELLS);
   localparam int ANG_W = $clog2(NUM_ANGLES);
   localparam int RAD_W = $clog2(NUM_RADIUS);
   localparam int CNT_W = $clog2(NUM_ANGLES + 1);
   localparam int VW    = (CNT_W > 9) ? CNT_W : 9;
   localparam int EXT   = (ACC_BITS > 32) ? ACC_BITS : 32;
   localparam int SW    = ((ACC_BITS > 17) ? ACC_BITS : 17) + 1;
   localparam logic [AW-1:0] NA_AW = AW'(NUM_ANGLES);

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_VOTE  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_READW = 6'b010000,
      ST_CLEAR = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [ANG_W-1:0] ang_ff, ang_in;
   logic [VW-1:0]    cnt_ff, cnt_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      bin_ff, bin_in;
   logic [8:0]       votes_ff, votes_in;
   logic signed [10:0] dy_ff, dx_ff;
   logic [16:0]      add_ff;

   // Pipeline registers of the vote path.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [15:0] sin1_ff, cos1_ff;
   logic signed [26:0] ps2_ff, pc2_ff;
   logic signed [27:0] r3_ff;
   logic signed [52:0] prod4_ff;
   logic [ANG_W-1:0] a1_ff, a2_ff, a3_ff, a4_ff;
   logic [AW-1:0]    addr5_ff;

   logic signed [15:0] sin_tab [NUM_ANGLES];
   logic signed [15:0] cos_tab [NUM_ANGLES];

   logic             hit4;
   logic [AW-1:0]    addr4;
   logic [AW-1:0]    rd_addr;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [ACC_BITS-1:0] ram_wdata;
   logic [ACC_BITS-1:0] ram_rdata;
   logic [SW-1:0]    sum5;
   logic [EXT-1:0]   rd_ext;
   logic [AW-1:0]    head_addr;

   // Sine and cosine for every angle, fixed at elaboration.
   for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_tab
      localparam logic [31:0] PH = 32'((64'(g) << 32) / NUM_ANGLES);
      assign sin_tab[g] = sin_q14(PH);
      assign cos_tab[g] = sin_q14(PH + 32'h4000_0000);
   end

   // Bin check and cell address at the end of the arithmetic chain.
   assign hit4  = v4_ff && !prod4_ff[52] && (prod4_ff[52:30] < 23'(NUM_RADIUS));
   assign addr4 = AW'(prod4_ff[30 +: RAD_W]) * NA_AW + AW'(a4_ff);
   assign head_addr = AW'(head.entry.rb) * NA_AW + AW'(head.entry.ab);
   assign rd_addr = (state_ff == ST_IDLE) ? head_addr : addr4;

   // Saturating update of the cell read back from memory.
   assign sum5 = SW'(ram_rdata) + SW'(add_ff);

   always_comb begin
      if (state_ff == ST_INIT || state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = v5_ff;
         ram_waddr = addr5_ff;
         ram_wdata = (sum5[SW-1:ACC_BITS] != '0) ? '1 : sum5[ACC_BITS-1:0];
      end
   end

   hlva_ram #(.WIDTH(ACC_BITS), .DEPTH(CELLS)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   assign rd_ext = EXT'(ram_rdata);
   assign pop    = (state_ff == ST_IDLE) && head.valid;

   // Sequencer for votes, reads and clearing sweeps.
   always_comb begin
      state_in     = state_ff;
      ang_in       = ang_ff;
      cnt_in       = v5_ff ? cnt_ff + 1'b1 : cnt_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      bin_in       = '0;
      votes_in     = '0;
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = (state_ff == ST_CLEAR);
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               case (head.entry.kind)
                  KIND_VOTE: begin
                     state_in = ST_VOTE;
                     ang_in   = '0;
                     cnt_in   = '0;
                  end
                  KIND_READ:  state_in = ST_READW;
                  KIND_CLEAR: begin
                     state_in = ST_CLEAR;
                     clr_in   = '0;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_VOTE: begin
            ang_in = ang_ff + 1'b1;
            if (ang_ff == ANG_W'(NUM_ANGLES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!(v1_ff || v2_ff || v3_ff || v4_ff || v5_ff)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               votes_in     = cnt_ff[8:0];
            end
         end
         ST_READW: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            bin_in       = (rd_ext > EXT'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : rd_ext[31:0];
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= '0;
         ang_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ang_ff       <= ang_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= (state_ff == ST_VOTE);
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= hit4;
      end
   end

   // Payload of the job, the pipeline and the response.
   always_ff @(posedge clock) begin
      if (pop) begin
         dy_ff  <= head.entry.dy;
         dx_ff  <= head.entry.dx;
         add_ff <= head.entry.add;
      end
      sin1_ff  <= sin_tab[ang_ff];
      cos1_ff  <= cos_tab[ang_ff];
      a1_ff    <= ang_ff;
      ps2_ff   <= sin1_ff * dy_ff;
      pc2_ff   <= cos1_ff * dx_ff;
      a2_ff    <= a1_ff;
      r3_ff    <= 28'(ps2_ff) + 28'(pc2_ff);
      a3_ff    <= a2_ff;
      prod4_ff <= r3_ff * $signed({1'b0, radius_scale});
      a4_ff    <= a3_ff;
      addr5_ff <= addr4;
      bin_ff   <= bin_in;
      votes_ff <= votes_in;
   end

   assign init_busy      = (state_ff == ST_INIT);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_value  = bin_ff;
   assign rsp_votes_cast = votes_ff;

endmodule
